FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/gprdz_pkg.sv
// ----------------------------------------------------------------------------
// gprdz_pkg
// Shared constants and types of the radial deadzone conditioner
// ----------------------------------------------------------------------------
package gprdz_pkg;

  localparam logic [14:0] FULL_SCALE = 15'h7FFF;

  // iteration count of the square root and of each division
  localparam int ITERS = 16;
  localparam int CNT_W = 4;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_DZ_LEFT   = 2'd0;
  localparam logic [1:0] REG_DZ_RIGHT  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [7:0] THRESHOLD_RST = 8'd128;

  // datapath operations issued by the controller
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
  localparam logic [OP_W-1:0] OP_MULX    = 4'd2;
  localparam logic [OP_W-1:0] OP_MULY    = 4'd3;
  localparam logic [OP_W-1:0] OP_SQLD    = 4'd4;
  localparam logic [OP_W-1:0] OP_SQSTEP  = 4'd5;
  localparam logic [OP_W-1:0] OP_DEN     = 4'd6;
  localparam logic [OP_W-1:0] OP_NUMX    = 4'd7;
  localparam logic [OP_W-1:0] OP_NUMY    = 4'd8;
  localparam logic [OP_W-1:0] OP_DIVLD   = 4'd9;
  localparam logic [OP_W-1:0] OP_DIVSTEP = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic capture;
    logic out_load;
  } seq_t;

endpackage

FILE: rtl/core/gamepad_radial_deadzone_conditioner.sv
// ----------------------------------------------------------------------------
// gamepad_radial_deadzone_conditioner
// Button edge masks, trigger crossings and scaled radial stick deadzones
// ----------------------------------------------------------------------------
//  port group   direction  handshake
//  poll in      input      in_valid / in_stall
//  result out   output     out_valid / out_stall
//  config       input      apb: psel penable pwrite paddr pwdata prdata pready
//
// one poll at a time: a new poll is taken only once the last result has gone to the output register
// each stick lane runs a 16-step square root and two 16-step divisions;
// both sticks run side by side in lanes of their own
// synchronous reset clears the button and trigger history and loads the
// register reset values (threshold 128)
// a finished result waits in the output register while the next poll is taken
module gamepad_radial_deadzone_conditioner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         pad_present,
  input  logic [15:0]                  button_bits,
  input  logic [7:0]                   left_trigger_raw,
  input  logic [7:0]                   right_trigger_raw,
  input  logic signed [15:0]           left_stick_x,
  input  logic signed [15:0]           left_stick_y,
  input  logic signed [15:0]           right_stick_x,
  input  logic signed [15:0]           right_stick_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         linked,
  output logic [15:0]                  buttons_down,
  output logic [15:0]                  buttons_pressed,
  output logic [15:0]                  buttons_released,
  output logic                         left_trigger_crossed,
  output logic                         right_trigger_crossed,
  output logic signed [15:0]           left_x_out,
  output logic signed [15:0]           left_y_out,
  output logic signed [15:0]           right_x_out,
  output logic signed [15:0]           right_y_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gprdz_pkg::ADDR_W-1:0] paddr,
  input  logic [gprdz_pkg::DATA_W-1:0] pwdata,
  output logic [gprdz_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  `include "assert_macros.svh"

  gprdz_pkg::cmd_t    cmd;
  gprdz_pkg::seq_t    seq;
  logic [14:0]        dz_left, dz_right;
  logic [7:0]         threshold;
  logic signed [15:0] lx, ly, rx, ry;

  logic [15:0] last_buttons;
  logic [7:0]  last_left_trigger, last_right_trigger;

  // event fields of the poll in flight
  logic        pres;
  logic [15:0] down, pressed, released;
  logic        ltc, rtc;

  logic        outs_zero, axes_in_range, masks_agree;

  gprdz_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .dz_left   (dz_left),
    .dz_right  (dz_right),
    .threshold (threshold)
  );

  gprdz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .seq       (seq)
  );

  gprdz_stick u_left (
    .clk   (clk),
    .cmd   (cmd),
    .x_raw (left_stick_x),
    .y_raw (left_stick_y),
    .dz    (dz_left),
    .x_out (lx),
    .y_out (ly)
  );

  gprdz_stick u_right (
    .clk   (clk),
    .cmd   (cmd),
    .x_raw (right_stick_x),
    .y_raw (right_stick_y),
    .dz    (dz_right),
    .x_out (rx),
    .y_out (ry)
  );

  // history; a missing pad clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      last_buttons       <= '0;
      last_left_trigger  <= '0;
      last_right_trigger <= '0;
    end else if (seq.capture) begin
      last_buttons       <= pad_present ? button_bits : 16'd0;
      last_left_trigger  <= pad_present ? left_trigger_raw : 8'd0;
      last_right_trigger <= pad_present ? right_trigger_raw : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.capture) begin
      pres     <= pad_present;
      down     <= pad_present ? button_bits : 16'd0;
      pressed  <= pad_present ? (button_bits & ~last_buttons) : 16'd0;
      released <= pad_present ? (~button_bits & last_buttons) : 16'd0;
      ltc      <= pad_present && (left_trigger_raw >= threshold)
                  && (last_left_trigger < threshold);
      rtc      <= pad_present && (right_trigger_raw >= threshold)
                  && (last_right_trigger < threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (seq.out_load) begin
      linked                <= pres;
      buttons_down          <= down;
      buttons_pressed       <= pressed;
      buttons_released      <= released;
      left_trigger_crossed  <= ltc;
      right_trigger_crossed <= rtc;
      left_x_out            <= pres ? lx : 16'sd0;
      left_y_out            <= pres ? ly : 16'sd0;
      right_x_out           <= pres ? rx : 16'sd0;
      right_y_out           <= pres ? ry : 16'sd0;
    end
  end

  assign outs_zero     = (buttons_down == 16'd0) && (left_x_out == 16'sd0)
                         && (left_y_out == 16'sd0) && (right_x_out == 16'sd0)
                         && (right_y_out == 16'sd0);
  assign axes_in_range = (left_x_out != 16'sh8000) && (left_y_out != 16'sh8000)
                         && (right_x_out != 16'sh8000) && (right_y_out != 16'sh8000);
  assign masks_agree   = ((buttons_pressed & ~buttons_down) == 16'd0)
                         && ((buttons_released & buttons_down) == 16'd0);

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accept while busy")
  `ASSERT_IMPL(a_unlinked_zero, clk, rst, out_valid && !linked, outs_zero, "unlinked result not zero")
  `ASSERT_IMPL(a_axis_range, clk, rst, out_valid, axes_in_range, "axis outside full scale")
  `ASSERT_IMPL(a_button_masks, clk, rst, out_valid, masks_agree, "button masks disagree")

endmodule

FILE: rtl/core/gprdz_cfg.sv
// ----------------------------------------------------------------------------
// gprdz_cfg
// APB register file: deadzone radii and trigger threshold
// ----------------------------------------------------------------------------
module gprdz_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gprdz_pkg::ADDR_W-1:0]    paddr,
  input  logic [gprdz_pkg::DATA_W-1:0]    pwdata,
  output logic [gprdz_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  output logic [14:0]                     dz_left,
  output logic [14:0]                     dz_right,
  output logic [7:0]                      threshold
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_left   <= '0;
      dz_right  <= '0;
      threshold <= gprdz_pkg::THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        gprdz_pkg::REG_DZ_LEFT:   dz_left   <= pwdata[14:0];
        gprdz_pkg::REG_DZ_RIGHT:  dz_right  <= pwdata[14:0];
        gprdz_pkg::REG_THRESHOLD: threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gprdz_pkg::REG_DZ_LEFT:   prdata = {17'd0, dz_left};
      gprdz_pkg::REG_DZ_RIGHT:  prdata = {17'd0, dz_right};
      gprdz_pkg::REG_THRESHOLD: prdata = {24'd0, threshold};
      default:                  prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/gprdz_stick.sv
// ----------------------------------------------------------------------------
// gprdz_stick
// One stick lane: shared multiplier, bit-serial square root, restoring divider
// ----------------------------------------------------------------------------
module gprdz_stick (
  input  logic               clk,
  input  gprdz_pkg::cmd_t    cmd,
  input  logic signed [15:0] x_raw,
  input  logic signed [15:0] y_raw,
  input  logic [14:0]        dz,
  output logic signed [15:0] x_out,
  output logic signed [15:0] y_out
);

  logic [15:0] ax, ay;
  logic        sx, sy;
  logic [31:0] prod, sq, den, rad;
  logic [17:0] rem_r;
  logic [15:0] root;
  logic [14:0] ld;
  logic        dead;
  logic [46:0] rem_d, dsh;
  logic [15:0] quo, qx;

  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [19:0] rem_sh, trial;
  logic        sq_ge;
  logic [14:0] legal;
  logic [14:0] span;
  logic [46:0] num_scaled;
  logic        div_ge;

  function automatic logic [15:0] signed_clamp(input logic [15:0] q, input logic neg);
    logic [14:0] qm;
    qm = (q > {1'b0, gprdz_pkg::FULL_SCALE}) ? gprdz_pkg::FULL_SCALE : q[14:0];
    return neg ? (16'd0 - {1'b0, qm}) : {1'b0, qm};
  endfunction

  assign span = gprdz_pkg::FULL_SCALE - dz;

  always_comb begin
    unique case (cmd.op)
      gprdz_pkg::OP_MULY: begin
        mul_a = ay;
        mul_b = ay;
      end
      gprdz_pkg::OP_DEN: begin
        mul_a = root;
        mul_b = {1'b0, span};
      end
      gprdz_pkg::OP_NUMX: begin
        mul_a = ax;
        mul_b = {1'b0, ld};
      end
      gprdz_pkg::OP_NUMY: begin
        mul_a = ay;
        mul_b = {1'b0, ld};
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
  end

  assign mul_p = {16'd0, mul_a} * {16'd0, mul_b};

  // two radicand bits per root bit
  assign rem_sh = {rem_r, rad[31:30]};
  assign trial  = {2'b00, root, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  assign legal      = (root > {1'b0, gprdz_pkg::FULL_SCALE}) ? gprdz_pkg::FULL_SCALE
                                                               : root[14:0];
  // num * 32767 as a shift and subtract
  assign num_scaled = {prod, 15'd0} - {15'd0, prod};
  assign div_ge     = rem_d >= dsh;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gprdz_pkg::OP_LOAD: begin
        sx <= x_raw[15];
        sy <= y_raw[15];
        ax <= x_raw[15] ? (16'd0 - x_raw) : x_raw;
        ay <= y_raw[15] ? (16'd0 - y_raw) : y_raw;
      end
      gprdz_pkg::OP_MULX: prod <= mul_p;
      gprdz_pkg::OP_MULY: begin
        sq   <= prod;
        prod <= mul_p;
      end
      gprdz_pkg::OP_SQLD: begin
        rad   <= sq + prod;
        rem_r <= '0;
        root  <= '0;
      end
      gprdz_pkg::OP_SQSTEP: begin
        rad <= {rad[29:0], 2'b00};
        if (sq_ge) begin
          rem_r <= 18'(rem_sh - trial);
          root  <= {root[14:0], 1'b1};
        end else begin
          rem_r <= rem_sh[17:0];
          root  <= {root[14:0], 1'b0};
        end
      end
      gprdz_pkg::OP_DEN: begin
        prod <= mul_p;
        dead <= (root <= {1'b0, dz}) || (dz == gprdz_pkg::FULL_SCALE);
        ld   <= legal - dz;
      end
      gprdz_pkg::OP_NUMX: begin
        den  <= prod;
        prod <= mul_p;
      end
      gprdz_pkg::OP_NUMY: begin
        qx   <= quo;
        prod <= mul_p;
      end
      gprdz_pkg::OP_DIVLD: begin
        rem_d <= num_scaled;
        dsh   <= {den, 15'd0};
        quo   <= '0;
      end
      gprdz_pkg::OP_DIVSTEP: begin
        if (div_ge) begin
          rem_d <= rem_d - dsh;
          quo   <= {quo[14:0], 1'b1};
        end else begin
          quo   <= {quo[14:0], 1'b0};
        end
        dsh <= {1'b0, dsh[46:1]};
      end
      default: ;
    endcase
  end

  assign x_out = dead ? 16'sd0 : signed'(signed_clamp(qx, sx));
  assign y_out = dead ? 16'sd0 : signed'(signed_clamp(quo, sy));

endmodule

FILE: rtl/core/gprdz_ctrl.sv
// ----------------------------------------------------------------------------
// gprdz_ctrl
// Sequencer: walks both stick lanes through root and divide, owns handshakes
// ----------------------------------------------------------------------------
module gprdz_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gprdz_pkg::cmd_t   cmd,
  output gprdz_pkg::seq_t   seq
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MULX   = 4'd1;
  localparam logic [3:0] S_MULY   = 4'd2;
  localparam logic [3:0] S_SQLD   = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_DEN    = 4'd5;
  localparam logic [3:0] S_NUMX   = 4'd6;
  localparam logic [3:0] S_DIVLDX = 4'd7;
  localparam logic [3:0] S_DIVX   = 4'd8;
  localparam logic [3:0] S_NUMY   = 4'd9;
  localparam logic [3:0] S_DIVLDY = 4'd10;
  localparam logic [3:0] S_DIVY   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  localparam logic [gprdz_pkg::CNT_W-1:0] LAST =
    gprdz_pkg::CNT_W'(gprdz_pkg::ITERS - 1);

  logic [3:0]                  state, state_next;
  logic [gprdz_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                        out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd.op       = gprdz_pkg::OP_NONE;
    seq.capture  = 1'b0;
    seq.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = gprdz_pkg::OP_LOAD;
          seq.capture = 1'b1;
          state_next  = S_MULX;
        end
      end
      S_MULX: begin
        cmd.op     = gprdz_pkg::OP_MULX;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.op     = gprdz_pkg::OP_MULY;
        state_next = S_SQLD;
      end
      S_SQLD: begin
        cmd.op     = gprdz_pkg::OP_SQLD;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op   = gprdz_pkg::OP_SQSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) state_next = S_DEN;
      end
      S_DEN: begin
        cmd.op     = gprdz_pkg::OP_DEN;
        state_next = S_NUMX;
      end
      S_NUMX: begin
        cmd.op     = gprdz_pkg::OP_NUMX;
        state_next = S_DIVLDX;
      end
      S_DIVLDX: begin
        cmd.op     = gprdz_pkg::OP_DIVLD;
        cnt_next   = '0;
        state_next = S_DIVX;
      end
      S_DIVX: begin
        cmd.op   = gprdz_pkg::OP_DIVSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) state_next = S_NUMY;
      end
      S_NUMY: begin
        cmd.op     = gprdz_pkg::OP_NUMY;
        state_next = S_DIVLDY;
      end
      S_DIVLDY: begin
        cmd.op     = gprdz_pkg::OP_DIVLD;
        cnt_next   = '0;
        state_next = S_DIVY;
      end
      S_DIVY: begin
        cmd.op   = gprdz_pkg::OP_DIVSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) state_next = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          seq.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (seq.out_load) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
